### hw/rtl/midi_encoder_step_decoder_top_defines.svh
// assertion macros for the midi encoder step decoder
// used by midi_encoder_step_decoder_top; clocked on aclk, reset by aresetn
`ifndef MIDI_ENCODER_STEP_DECODER_TOP_DEFINES_SVH
`define MIDI_ENCODER_STEP_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define MESD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("mesd assertion failed");

// checked at every edge, reset included
`define MESD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("mesd assertion failed");

`else

`define MESD_ASSERT(lbl, prop)
`define MESD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### hw/rtl/mesd_pkg.sv
// types and constants for the midi encoder step decoder
// no dependencies
`timescale 1ns / 1ps

package mesd_pkg;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2
    } action_t;

    localparam logic [1:0] MODE_RELATIVE = 2'd0;
    localparam logic [1:0] MODE_RANGE    = 2'd1;
    localparam logic [1:0] MODE_FIXED    = 2'd2;

    localparam logic [2:0] CFG_DECODE_MODE    = 3'd0;
    localparam logic [2:0] CFG_PRESCALE_DELAY = 3'd1;
    localparam logic [2:0] CFG_CODE_LOW       = 3'd2;
    localparam logic [2:0] CFG_CODE_HIGH      = 3'd3;
    localparam logic [2:0] CFG_UP_STEPS       = 3'd4;
    localparam logic [2:0] CFG_DOWN_STEPS     = 3'd5;
    localparam logic [2:0] CFG_VALUE_FLOOR    = 3'd6;
    localparam logic [2:0] CFG_VALUE_CEILING  = 3'd7;

    localparam logic [6:0] REL_CENTER    = 7'd64;
    localparam logic [6:0] REL_FAST_DOWN = 7'd61;
    localparam logic [6:0] REL_FAST_UP   = 7'd68;

    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

endpackage

### hw/rtl/midi_encoder_step_decoder_top.sv
// midi encoder step decoder: decode stage and step/clamp stage with output register
// depends on mesd_pkg and midi_encoder_step_decoder_top_defines.svh
`timescale 1ns / 1ps
`include "midi_encoder_step_decoder_top_defines.svh"

// Takes one controller word per cycle and returns exactly one result word for each,
// in order. The first stage applies the layer match, the prescaler and the mode decode
// and updates the decoder state; the second adds the chosen Q16.16 step, saturates and
// clamps into the output register. Throughput is one word per clock as long as m_tready
// stays high; a stall holds both stages and drops s_tready once they are full.
// Configuration is written through cfg_we, cfg_index and cfg_wdata and should only
// change while no word is in flight.
module midi_encoder_step_decoder_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [mesd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mesd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mesd_pkg::IN_DATA_W-1:0]      s_tdata,  // code[6:0], current_value[38:7], zero
    input  logic                                s_tuser,  // layer_ok[0]
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mesd_pkg::OUT_DATA_W-1:0]     m_tdata   // action[1:0], fast[2], new_value[34:3], zero
);
    import mesd_pkg::*;

    // configuration
    logic [1:0]         decode_mode_reg;
    logic signed [8:0]  prescale_delay_reg;
    logic [6:0]         code_low_reg;
    logic [6:0]         code_high_reg;
    logic [63:0]        up_steps_reg;
    logic [63:0]        down_steps_reg;
    logic signed [31:0] value_floor_reg;
    logic signed [31:0] value_ceiling_reg;

    // decoder state
    logic [7:0] skip_count_reg, skip_count_next;
    logic       prev_seen_reg, prev_seen_next;
    logic [6:0] prev_code_reg, prev_code_next;

    // decode stage
    logic               s1_valid_reg;
    action_t            s1_action_reg;
    logic               s1_fast_reg;
    logic signed [31:0] s1_step_reg;
    logic signed [31:0] s1_cur_reg;

    // output register
    logic               out_valid_reg;
    action_t            out_action_reg;
    logic               out_fast_reg;
    logic signed [31:0] out_value_reg;

    logic               s_accept;
    logic               out_load;
    logic [6:0]         in_code;
    logic signed [31:0] in_cur;
    logic               go;
    action_t            dec_action;
    logic               dec_fast;
    logic signed [31:0] dec_step;
    logic signed [32:0] sum;
    logic signed [31:0] sat_value;
    logic signed [31:0] step_value;

    assign in_code = s_tdata[6:0];
    assign in_cur  = s_tdata[38:7];

    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || out_load;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decode_mode_reg    <= MODE_RELATIVE;
            prescale_delay_reg <= -9'sd1;
            code_low_reg       <= 7'd0;
            code_high_reg      <= 7'd127;
            up_steps_reg       <= 64'd0;
            down_steps_reg     <= 64'd0;
            value_floor_reg    <= Q_MIN;
            value_ceiling_reg  <= Q_MAX;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DECODE_MODE:    decode_mode_reg    <= cfg_wdata[1:0];
                CFG_PRESCALE_DELAY: prescale_delay_reg <= cfg_wdata[8:0];
                CFG_CODE_LOW:       code_low_reg       <= cfg_wdata[6:0];
                CFG_CODE_HIGH:      code_high_reg      <= cfg_wdata[6:0];
                CFG_UP_STEPS:       up_steps_reg       <= cfg_wdata;
                CFG_DOWN_STEPS:     down_steps_reg     <= cfg_wdata;
                CFG_VALUE_FLOOR:    value_floor_reg    <= cfg_wdata[31:0];
                CFG_VALUE_CEILING:  value_ceiling_reg  <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // layer match, prescaler and mode decode
    always_comb begin
        go              = s_tuser;
        dec_action      = ACT_NONE;
        dec_fast        = 1'b0;
        skip_count_next = skip_count_reg;
        prev_seen_next  = prev_seen_reg;
        prev_code_next  = prev_code_reg;

        if (go && !prescale_delay_reg[8]) begin
            if (skip_count_reg < prescale_delay_reg[7:0]) begin
                skip_count_next = skip_count_reg + 8'd1;
                go              = 1'b0;
            end else begin
                skip_count_next = 8'd0;
            end
        end

        if (go) begin
            case (decode_mode_reg)
                MODE_RELATIVE: begin
                    if (in_code < REL_CENTER) begin
                        dec_action = ACT_DOWN;
                        dec_fast   = in_code < REL_FAST_DOWN;
                    end else if (in_code > REL_CENTER) begin
                        dec_action = ACT_UP;
                        dec_fast   = in_code > REL_FAST_UP;
                    end
                end
                MODE_RANGE: begin
                    // the first word only primes the previous code
                    if (!prev_seen_reg) begin
                        prev_seen_next = 1'b1;
                    end else if (in_code == code_low_reg) begin
                        dec_action = ACT_DOWN;
                    end else if (in_code == code_high_reg) begin
                        dec_action = ACT_UP;
                    end else if (in_code > prev_code_reg) begin
                        dec_action = ACT_UP;
                    end else begin
                        dec_action = ACT_DOWN;
                    end
                    prev_code_next = in_code;
                end
                MODE_FIXED: begin
                    if (in_code == code_low_reg) begin
                        dec_action = ACT_DOWN;
                    end else if (in_code == code_high_reg) begin
                        dec_action = ACT_UP;
                    end
                end
                default: ;
            endcase
        end

        case (dec_action)
            ACT_UP:   dec_step = dec_fast ? up_steps_reg[63:32] : up_steps_reg[31:0];
            ACT_DOWN: dec_step = dec_fast ? down_steps_reg[63:32] : down_steps_reg[31:0];
            default:  dec_step = 32'sd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_count_reg <= 8'd0;
            prev_seen_reg  <= 1'b0;
            prev_code_reg  <= 7'd0;
            s1_valid_reg   <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s_accept) begin
                skip_count_reg <= skip_count_next;
                prev_seen_reg  <= prev_seen_next;
                prev_code_reg  <= prev_code_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_action_reg <= dec_action;
            s1_fast_reg   <= dec_fast;
            s1_step_reg   <= dec_step;
            s1_cur_reg    <= in_cur;
        end
    end

    // add, saturate to 32 bits, then clamp on the side of the step's sign
    assign sum = {s1_cur_reg[31], s1_cur_reg} + {s1_step_reg[31], s1_step_reg};

    always_comb begin
        if (sum > 33'sh0_7fff_ffff) begin
            sat_value = Q_MAX;
        end else if (sum < -33'sh0_8000_0000) begin
            sat_value = Q_MIN;
        end else begin
            sat_value = sum[31:0];
        end

        if (s1_action_reg == ACT_NONE) begin
            step_value = s1_cur_reg;
        end else if (s1_step_reg[31]) begin
            step_value = (sat_value < value_floor_reg) ? value_floor_reg : sat_value;
        end else begin
            step_value = (sat_value > value_ceiling_reg) ? value_ceiling_reg : sat_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_action_reg <= s1_action_reg;
            out_fast_reg   <= s1_fast_reg;
            out_value_reg  <= step_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_value_reg, out_fast_reg, out_action_reg};

    `MESD_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !out_valid_reg && !s1_valid_reg)
    `MESD_ASSERT(a_fast_needs_action,
        out_valid_reg && out_fast_reg |-> out_action_reg != ACT_NONE)
    `MESD_ASSERT(a_idle_keeps_value,
        out_load && s1_action_reg == ACT_NONE |=> out_value_reg == $past(s1_cur_reg))
    `MESD_ASSERT(a_primed_stays, prev_seen_reg |=> prev_seen_reg)

endmodule
